// ===== hw/rtl/cfs_pkg.sv =====
// Package for the compensated binary64 summation core.
// Holds field widths, binary64 constants and shared types. No dependencies.
`default_nettype none
package cfs_pkg;
  localparam int unsigned FP_W   = 64;
  localparam int unsigned EXP_W  = 11;
  localparam int unsigned FRAC_W = 52;
  localparam logic [FP_W-1:0] FP_POS_ZERO = 64'h0;
  localparam logic [FP_W-1:0] FP_QNAN     = 64'h7FF8_0000_0000_0000;
  localparam logic [EXP_W-1:0] EXP_MAX    = '1;

  typedef logic [FP_W-1:0] fp64_t;

  // Input beat payload
  typedef struct packed {
    fp64_t summand;
    logic  last;
  } cfs_in_t;
endpackage
`default_nettype wire

// ===== hw/rtl/cfs_stream_if.sv =====
// Valid/ready stream interface used by the summation core channels.
// Depends on nothing; payload width is a parameter.
`default_nettype none
interface cfs_stream_if #(
  parameter int unsigned W = 64
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cfs_fp_add.sv =====
// Combinational binary64 adder, round-to-nearest-even, full subnormal and
// special-value handling. Uses cfs_pkg.
`default_nettype none
module cfs_fp_add
  import cfs_pkg::*;
(
  input  wire fp64_t a,
  input  wire fp64_t b,
  input  wire logic  sub,
  output fp64_t      sum
);
  localparam int unsigned MW = FRAC_W + 4; // hidden + frac + guard,round,sticky

  logic              sa, sb;
  logic [EXP_W-1:0]  ea, eb;
  logic [FRAC_W-1:0] fa, fb;
  logic              a_nan, b_nan, a_inf, b_inf;
  logic [EXP_W-1:0]  ea_e, eb_e;
  logic [FRAC_W:0]   ma, mb;
  logic              swap;
  logic              sx, sy;
  logic [EXP_W-1:0]  ex, ey;
  logic [FRAC_W:0]   mx, my;
  logic [EXP_W-1:0]  dexp;
  logic [MW-1:0]     xx, yy, ysh;
  logic              stk;
  logic [MW:0]       rsum;
  logic              eff_sub;
  logic [5:0]        lz;
  logic [MW:0]       norm;
  logic [EXP_W+1:0]  enorm;
  logic [EXP_W+1:0]  shamt;
  logic [FRAC_W:0]   mant;
  logic              g, r, s, rup;
  logic [FRAC_W+1:0] mrnd;
  logic [EXP_W+1:0]  efin;
  logic              rsign;

  always_comb begin
    sa = a[63];
    sb = b[63] ^ sub;
    ea = a[62:52];
    eb = b[62:52];
    fa = a[51:0];
    fb = b[51:0];
    a_nan = (ea == EXP_MAX) && (fa != '0);
    b_nan = (eb == EXP_MAX) && (fb != '0);
    a_inf = (ea == EXP_MAX) && (fa == '0);
    b_inf = (eb == EXP_MAX) && (fb == '0);
    ea_e = (ea == '0) ? EXP_W'(1) : ea;
    eb_e = (eb == '0) ? EXP_W'(1) : eb;
    ma = {ea != '0, fa};
    mb = {eb != '0, fb};
    // Larger magnitude first
    swap = {ea_e, ma} < {eb_e, mb};
    sx = swap ? sb : sa;
    sy = swap ? sa : sb;
    ex = swap ? eb_e : ea_e;
    ey = swap ? ea_e : eb_e;
    mx = swap ? mb : ma;
    my = swap ? ma : mb;
    dexp = ex - ey;
    xx = {mx, 3'b000};
    yy = {my, 3'b000};
    // Align smaller operand with sticky collection
    if (dexp >= EXP_W'(MW)) begin
      ysh = '0;
      stk = (my != '0);
    end else begin
      ysh = yy >> dexp;
      stk = ((yy & ~({MW{1'b1}} << dexp)) != '0);
    end
    ysh[0] = ysh[0] | stk;
    eff_sub = sx ^ sy;
    rsum = eff_sub ? ({1'b0, xx} - {1'b0, ysh}) : ({1'b0, xx} + {1'b0, ysh});
    // Leading zero count over rsum
    lz = 6'd57;
    for (int i = 0; i <= MW; i++) begin
      if (rsum[i]) lz = 6'(MW - i);
    end
    // Normalize: target leading one at bit MW-1 (value 1.x at ex)
    shamt = '0;
    if (rsum[MW]) begin
      norm  = {1'b0, rsum[MW:2], rsum[1] | rsum[0]};
      enorm = {2'b00, ex} + 1'b1;
    end else begin
      // left shift by lz-1, limited so exponent stays >= 1
      shamt = {7'b0, lz} - 1'b1;
      if ({2'b00, ex} <= shamt) shamt = {2'b00, ex} - 1'b1;
      norm  = rsum << shamt;
      enorm = {2'b00, ex} - shamt;
    end
    mant = norm[MW-1:3];
    g = norm[2];
    r = norm[1];
    s = norm[0];
    rup = g & (r | s | mant[0]);
    mrnd = {1'b0, mant} + (FRAC_W+2)'(rup);
    efin = enorm;
    if (mrnd[FRAC_W+1]) begin
      mrnd = mrnd >> 1;
      efin = enorm + 1'b1;
    end
    rsign = sx;
    if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
      sum = FP_QNAN;
    end else if (a_inf) begin
      sum = {sa, EXP_MAX, {FRAC_W{1'b0}}};
    end else if (b_inf) begin
      sum = {sb, EXP_MAX, {FRAC_W{1'b0}}};
    end else if (rsum == '0) begin
      sum = {sa & sb, {(FP_W-1){1'b0}}};
    end else if (efin >= {2'b00, EXP_MAX}) begin
      sum = {rsign, EXP_MAX, {FRAC_W{1'b0}}};
    end else if (!mrnd[FRAC_W]) begin
      sum = {rsign, {EXP_W{1'b0}}, mrnd[FRAC_W-1:0]};
    end else begin
      sum = {rsign, efin[EXP_W-1:0], mrnd[FRAC_W-1:0]};
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/compensated_float_sum_core.sv =====
// Top level of the compensated binary64 summation core.
// Uses cfs_pkg, cfs_stream_if and four cfs_fp_add instances.
`default_nettype none
// Kahan summation of a binary64 stream: y = x - c, t = s + y,
// c = (t - s) - y, s = t. One summand is accepted every cycle; each beat is
// registered and then folded into the running sum and compensation by a
// chain of four adders, and on a beat marked last the final sum lands in
// the output register while both state registers return to +0. A NaN total
// is delivered as the canonical quiet NaN. Input stalls only when the output
// register holds an untaken result and a new one would be produced.
module compensated_float_sum_core
  import cfs_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  cfs_stream_if.sink   in_s,
  cfs_stream_if.source out_s
);
  logic    in_vld_r;
  cfs_in_t in_r;
  fp64_t   sum_r, comp_r;
  logic    out_vld_r;
  fp64_t   out_r;
  fp64_t   y, t, d, lost;
  logic    stall;

  cfs_fp_add u_y (.a(in_r.summand), .b(comp_r), .sub(1'b1), .sum(y));
  cfs_fp_add u_t (.a(sum_r), .b(y), .sub(1'b0), .sum(t));
  cfs_fp_add u_d (.a(t), .b(sum_r), .sub(1'b1), .sum(d));
  cfs_fp_add u_l (.a(d), .b(y), .sub(1'b1), .sum(lost));

  // Held item would emit while the output is still full
  assign stall      = in_vld_r && in_r.last && out_vld_r && !out_s.ready;
  assign in_s.ready = !stall;
  assign out_s.valid = out_vld_r;
  assign out_s.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      sum_r     <= FP_POS_ZERO;
      comp_r    <= FP_POS_ZERO;
    end else begin
      // Input register
      if (!stall) begin
        in_vld_r <= in_s.valid;
        if (in_s.valid) in_r <= {in_s.data[64:1], in_s.data[0]};
      end
      // Output register: load a total, clear once taken
      if (!stall && in_vld_r && in_r.last) begin
        out_vld_r <= 1'b1;
        out_r     <= ((t[62:52] == EXP_MAX) && (t[51:0] != '0)) ? FP_QNAN : t;
      end else if (out_s.ready) begin
        out_vld_r <= 1'b0;
      end
      // Running state
      if (!stall && in_vld_r) begin
        if (in_r.last) begin
          sum_r  <= FP_POS_ZERO;
          comp_r <= FP_POS_ZERO;
        end else begin
          sum_r  <= t;
          comp_r <= lost;
        end
      end
    end
  end
endmodule
`default_nettype wire
